// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the stepper sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a, outside reset.
`define ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("stepper sequencer check failed");

// Condition c must hold in the cycle after a, outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("stepper sequencer check failed");

`endif

// ----- hdl/ssdseq_pkg.sv -----
// Types, constants and the coil table of the stepper speed and direction sequencer.
package ssdseq_pkg;

  // Field widths.
  localparam int KeyBits     = 8;
  localparam int CoilBits    = 4;
  localparam int SpeedBits   = 4;
  localparam int PhaseBits   = 2;
  localparam int BaseBits    = 16;
  localparam int StepBits    = 12;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 16;

  // Default width of the tick counter.
  localparam int CounterBitsDefault = 16;

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [CoilBits-1:0]  coil_t;
  typedef logic [SpeedBits-1:0] speed_t;
  typedef logic [PhaseBits-1:0] phase_t;
  typedef logic [BaseBits-1:0]  base_t;
  typedef logic [StepBits-1:0]  pstep_t;

  // Item kinds.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  // Turning direction, coded as a two's complement value.
  typedef enum logic [1:0] {
    DIR_STOP  = 2'b00,
    DIR_RIGHT = 2'b01,
    DIR_LEFT  = 2'b11
  } dir_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    REG_BASE_PERIOD = 1'b0,
    REG_PERIOD_STEP = 1'b1
  } cfg_reg_t;

  // Key codes (ASCII digits).
  localparam key_t KeyFaster = 8'h32;
  localparam key_t KeyLeft   = 8'h34;
  localparam key_t KeyStop   = 8'h35;
  localparam key_t KeyRight  = 8'h36;
  localparam key_t KeySlower = 8'h38;

  // Speed limits and reset values.
  localparam speed_t SpeedMin   = 4'd1;
  localparam speed_t SpeedMax   = 4'd9;
  localparam speed_t SpeedReset = 4'd5;
  localparam base_t  BaseReset  = 16'd640;
  localparam pstep_t StepReset  = 12'd64;

  // Full-step coil pattern for each phase.
  function automatic coil_t coil_pattern(input phase_t phase);
    coil_t pat;
    unique case (phase)
      2'd0:    pat = 4'hC;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'h3;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

// ----- hdl/ssdseq_if.sv -----
// Channel interfaces of the stepper sequencer: input items, results and configuration.

// Input items: a timer tick or a key press.
interface ssdseq_in_if;
  import ssdseq_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [KeyBits-1:0] key_code;
  modport source (output valid, op, key_code, input ready);
  modport sink (input valid, op, key_code, output ready);
endinterface

// Result items: coil drive and motor status.
interface ssdseq_out_if;
  import ssdseq_pkg::*;
  logic valid;
  logic ready;
  logic [CoilBits-1:0] coils;
  logic signed [1:0] direction;
  logic [SpeedBits-1:0] speed;
  logic stepped;
  modport source (output valid, coils, direction, speed, stepped, input ready);
  modport sink (input valid, coils, direction, speed, stepped, output ready);
endinterface

// Configuration register writes.
interface ssdseq_cfg_if;
  import ssdseq_pkg::*;
  logic valid;
  logic ready;
  logic [CfgIdxBits-1:0] index;
  logic [CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/ssdseq_period.sv -----
// Configuration registers and the registered step period of the stepper sequencer.
module ssdseq_period #(
  parameter int COUNTER_BITS = ssdseq_pkg::CounterBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  ssdseq_cfg_if.sink                 cfg,
  input  ssdseq_pkg::speed_t         speed_next,
  output logic [COUNTER_BITS-1:0]    period
);
  import ssdseq_pkg::*;

  base_t  base_period;
  pstep_t period_step;
  base_t  base_next;
  pstep_t step_next;
  speed_t speed_eff;
  base_t  cut;
  base_t  period_raw;
  logic   cfg_fire;
  logic [COUNTER_BITS-1:0] period_next;

  // Writes are taken whenever the block is out of reset.
  assign cfg.ready = ~rst;
  assign cfg_fire  = cfg.valid & cfg.ready;

  // Register values as they stand after this edge.
  always_comb begin
    base_next = base_period;
    step_next = period_step;
    speed_eff = speed_next;
    if (rst) begin
      base_next = BaseReset;
      step_next = StepReset;
      speed_eff = SpeedReset;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_BASE_PERIOD: base_next = cfg.data[BaseBits-1:0];
        REG_PERIOD_STEP: step_next = cfg.data[StepBits-1:0];
        default: ;
      endcase
    end
  end

  // Period is the base less step times speed, floored at zero.
  always_comb begin
    cut        = BaseBits'(step_next) * BaseBits'(speed_eff);
    period_raw = (base_next > cut) ? (base_next - cut) : '0;
  end

  // Cap the period at the counter maximum when the counter is narrow.
  if (COUNTER_BITS >= BaseBits) begin : g_wide
    assign period_next = COUNTER_BITS'(period_raw);
  end else begin : g_narrow
    assign period_next = (period_raw[BaseBits-1:COUNTER_BITS] != '0)
                       ? {COUNTER_BITS{1'b1}} : period_raw[COUNTER_BITS-1:0];
  end

  // Configuration registers and the period, which tracks the next speed.
  always_ff @(posedge clk) begin
    base_period <= base_next;
    period_step <= step_next;
    period      <= period_next;
  end

endmodule

// ----- hdl/stepper_speed_direction_sequencer.sv -----
// Top level of the key-driven full-step stepper motor sequencer.
//
//   channel  | role   | payload
//   ---------+--------+------------------------------------------
//   in_item  | sink   | op, key_code
//   out_item | source | coils, direction, speed, stepped
//   cfg      | sink   | index, data (base_period, period_step)
//
// The state update and the result are formed by one compare and increment
// between the state and the result register. A new item is accepted in
// every cycle while the result register is empty or its result is being
// taken in the same cycle. Synchronous reset clears the result register
// and restores the motor state and configuration; no transfer is accepted
// during reset.
module stepper_speed_direction_sequencer #(
  parameter int COUNTER_BITS = ssdseq_pkg::CounterBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  ssdseq_in_if.sink   in_item,
  ssdseq_out_if.source out_item,
  ssdseq_cfg_if.sink  cfg
);
  import ssdseq_pkg::*;

  // Motor state.
  dir_t   turn_dir;
  speed_t speed_level;
  phase_t phase_index;
  coil_t  coil_bits;
  logic [COUNTER_BITS-1:0] tick_count;

  dir_t   turn_dir_next;
  speed_t speed_level_next;
  phase_t phase_index_next;
  coil_t  coil_bits_next;
  logic [COUNTER_BITS-1:0] tick_count_next;
  logic   stepped_next;

  // Result register.
  logic   out_valid;
  coil_t  out_coils;
  dir_t   out_dir;
  speed_t out_speed;
  logic   out_stepped;

  logic [COUNTER_BITS-1:0] period;
  logic in_fire;

  // Period and configuration registers.
  ssdseq_period #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_period (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .speed_next (speed_level_next),
    .period     (period)
  );

  // Accept while the result register is free or being emptied.
  assign in_item.ready = ~rst & (~out_valid | out_item.ready);
  assign in_fire       = in_item.valid & in_item.ready;

  // Next motor state for the item in transfer.
  always_comb begin
    turn_dir_next    = turn_dir;
    speed_level_next = speed_level;
    phase_index_next = phase_index;
    coil_bits_next   = coil_bits;
    tick_count_next  = tick_count;
    stepped_next     = 1'b0;
    if (in_fire) begin
      if (op_t'(in_item.op) == OP_KEY) begin
        unique case (in_item.key_code)
          KeyStop: turn_dir_next = DIR_STOP;
          KeyLeft: begin
            if (turn_dir != DIR_LEFT) begin
              turn_dir_next   = DIR_LEFT;
              tick_count_next = '0;
            end
          end
          KeyRight: begin
            if (turn_dir != DIR_RIGHT) begin
              turn_dir_next   = DIR_RIGHT;
              tick_count_next = '0;
            end
          end
          KeyFaster: begin
            if (speed_level < SpeedMax) speed_level_next = speed_level + 1'b1;
          end
          KeySlower: begin
            if (speed_level > SpeedMin) speed_level_next = speed_level - 1'b1;
          end
          default: ;
        endcase
      end else if (turn_dir != DIR_STOP) begin
        // A tick while turning either steps or counts on.
        if (tick_count >= period) begin
          coil_bits_next   = coil_pattern(phase_index);
          phase_index_next = (turn_dir == DIR_RIGHT) ? phase_index + 1'b1
                                                     : phase_index - 1'b1;
          tick_count_next  = '0;
          stepped_next     = 1'b1;
        end else begin
          tick_count_next = tick_count + 1'b1;
        end
      end
    end
  end

  // Motor state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_dir    <= DIR_STOP;
      speed_level <= SpeedReset;
      phase_index <= '0;
      coil_bits   <= '0;
      tick_count  <= '0;
    end else begin
      turn_dir    <= turn_dir_next;
      speed_level <= speed_level_next;
      phase_index <= phase_index_next;
      coil_bits   <= coil_bits_next;
      tick_count  <= tick_count_next;
    end
  end

  // Result register: loaded on an input transfer, freed on an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_coils   <= coil_bits_next;
      out_dir     <= turn_dir_next;
      out_speed   <= speed_level_next;
      out_stepped <= stepped_next;
    end
  end

  assign out_item.valid     = out_valid;
  assign out_item.coils     = out_coils;
  assign out_item.direction = $signed(out_dir);
  assign out_item.speed     = out_speed;
  assign out_item.stepped   = out_stepped;

endmodule

// ----- hdl/ssdseq_checker.sv -----
// Port-level checks of the stepper sequencer and their binding to the top level.
`include "assert_macros.svh"

module ssdseq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        out_coils,
  input logic signed [1:0] out_direction,
  input logic [3:0]        out_speed,
  input logic              out_stepped
);
  import ssdseq_pkg::*;

  logic        speed_ok;
  logic [10:0] out_payload;

  // Speed within its limits, and the whole result payload as one word.
  assign speed_ok    = (out_speed >= SpeedMin) && (out_speed <= SpeedMax);
  assign out_payload = {out_coils, out_direction, out_speed, out_stepped};

  // The reported speed always lies within its limits.
  `ASSERT_SAME(a_speed_range, clk, rst, out_valid, speed_ok)

  // A step is only ever reported while the motor turns.
  `ASSERT_SAME(a_step_turning, clk, rst, out_valid && out_stepped, out_direction != 2'sd0)

  // A key press gives its result in the next cycle and never steps.
  `ASSERT_NEXT(a_key_result, clk, rst, in_valid && in_ready && in_op, out_valid && !out_stepped)

  // A stalled result holds still until it is taken.
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_payload))

endmodule

bind stepper_speed_direction_sequencer ssdseq_checker u_ssdseq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .in_op         (in_item.op),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .out_coils     (out_item.coils),
  .out_direction (out_item.direction),
  .out_speed     (out_item.speed),
  .out_stepped   (out_item.stepped)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the stepper speed and direction sequencer.
module testbench;
  import ssdseq_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 4;
  localparam int ChunkItems   = 50;
  localparam logic [15:0] CountMax = 16'hFFFF;

  // Full-step coil drive, indexed by phase.
  localparam coil_t FullStep [4] = '{4'hC, 4'h6, 4'h3, 4'h9};

  typedef struct packed {
    coil_t  coils;
    dir_t   direction;
    speed_t speed;
    logic   stepped;
  } motor_status_t;

  logic clk;
  logic rst;

  ssdseq_in_if  in_item ();
  ssdseq_out_if out_item ();
  ssdseq_cfg_if cfg ();

  stepper_speed_direction_sequencer uut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg      (cfg)
  );

  // Predicted motor state and register contents, starting from their reset values.
  dir_t        model_dir   = DIR_STOP;
  speed_t      model_speed = SpeedReset;
  phase_t      model_phase = '0;
  logic [15:0] model_count = '0;
  coil_t       model_coils = '0;
  base_t       model_base  = BaseReset;
  pstep_t      model_pstep = StepReset;

  motor_status_t expected_status [$];
  int error_count = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Applies one item to the predicted state and returns the status it produces.
  function automatic motor_status_t advance_motor(op_t op, key_t key);
    logic [16:0]   cut;
    logic [16:0]   period;
    motor_status_t status;
    cut    = model_pstep * model_speed;
    period = (model_base > cut) ? model_base - cut : 17'd0;
    if (period > CountMax) begin
      period = CountMax;
    end
    status.stepped = 1'b0;
    if (op == OP_KEY) begin
      case (key)
        KeyStop: model_dir = DIR_STOP;
        KeyLeft, KeyRight: begin
          // Only a change of direction restarts the period count.
          if (model_dir != ((key == KeyLeft) ? DIR_LEFT : DIR_RIGHT)) begin
            model_dir   = (key == KeyLeft) ? DIR_LEFT : DIR_RIGHT;
            model_count = '0;
          end
        end
        KeyFaster: if (model_speed < SpeedMax) model_speed = model_speed + 1'b1;
        KeySlower: if (model_speed > SpeedMin) model_speed = model_speed - 1'b1;
        default: ;
      endcase
    end else if (model_dir != DIR_STOP) begin
      if ({1'b0, model_count} >= period) begin
        model_coils    = FullStep[model_phase];
        model_phase    = (model_dir == DIR_RIGHT) ? model_phase + 2'd1 : model_phase - 2'd1;
        model_count    = '0;
        status.stepped = 1'b1;
      end else if (model_count < CountMax) begin
        model_count = model_count + 1'b1;
      end
    end
    status.coils     = model_coils;
    status.direction = model_dir;
    status.speed     = model_speed;
    return status;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Watch every transfer: register writes and items update the prediction,
  // results are compared with the oldest prediction.
  always @(posedge clk) begin
    motor_status_t want;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_BASE_PERIOD: model_base = cfg.data;
          REG_PERIOD_STEP: model_pstep = cfg.data[StepBits-1:0];
          default: ;
        endcase
      end
      if (out_item.valid && out_item.ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("result arrived with no status predicted");
        end else begin
          want = expected_status.pop_front();
          if (out_item.coils !== want.coils)
            report_mismatch($sformatf("coils %h, predicted %h", out_item.coils, want.coils));
          if (out_item.direction !== want.direction)
            report_mismatch($sformatf("direction %b, predicted %b",
                                      out_item.direction, want.direction));
          if (out_item.speed !== want.speed)
            report_mismatch($sformatf("speed %0d, predicted %0d", out_item.speed, want.speed));
          if (out_item.stepped !== want.stepped)
            report_mismatch($sformatf("stepped %b, predicted %b",
                                      out_item.stepped, want.stepped));
        end
      end
      if (in_item.valid && in_item.ready) begin
        expected_status.push_back(advance_motor(op_t'(in_item.op), in_item.key_code));
      end
    end
  end

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    out_item.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", CycleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one item, with random idle cycles ahead of it; valid stays high on return.
  task automatic send_item(op_t op, key_t key);
    while ($urandom_range(99) < idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid    <= 1'b1;
    in_item.op       <= op;
    in_item.key_code <= key;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
  endtask

  task automatic send_key(key_t key);
    send_item(OP_KEY, key);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, key_t'($urandom_range(255)));
  endtask

  // Holds the input until every predicted status has been taken.
  task automatic wait_results_drained();
    in_item.valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(logic [15:0] base, logic [15:0] step);
    write_register(REG_BASE_PERIOD, base);
    write_register(REG_PERIOD_STEP, step);
  endtask

  // Mostly ticks and valid keys, with some arbitrary key codes.
  task automatic send_random_item();
    int   pick;
    key_t key;
    pick = $urandom_range(99);
    key  = key_t'($urandom_range(255));
    if (pick < 60) begin
      send_item(OP_TICK, key);
    end else if (pick < 92) begin
      case ($urandom_range(4))
        0:       key = KeyStop;
        1:       key = KeyLeft;
        2:       key = KeyRight;
        3:       key = KeyFaster;
        default: key = KeySlower;
      endcase
      send_key(key);
    end else begin
      send_key(key);
    end
  endtask

  // Stopped motor, unknown keys, repeated and new directions, and holding on stop.
  // The period is floored at zero here, so every turning tick steps.
  task automatic test_key_handling();
    set_timing(16'd64, 16'd32);
    send_tick();
    send_key(8'h00);
    send_key(8'hFF);
    send_key(KeyStop);
    send_key(KeyRight);
    send_tick();
    send_tick();
    send_key(KeyRight);
    send_key(KeyLeft);
    send_tick();
    send_key(KeyStop);
    send_tick();
    wait_results_drained();
  endtask

  // Speed up past the top limit, then down past the bottom one.
  task automatic test_speed_limits();
    repeat (5) send_key(KeyFaster);
    repeat (9) send_key(KeySlower);
    wait_results_drained();
  endtask

  // At speed one the period is 32; raising the speed drops it to zero while the
  // counter is already past it, so the next tick steps.
  task automatic test_shortened_period();
    send_key(KeyRight);
    repeat (3) send_tick();
    send_key(KeyFaster);
    send_tick();
    wait_results_drained();
  endtask

  // Register extremes, each with a short burst of items under mixed idling.
  task automatic test_register_extremes();
    idle_pct  = 30;
    stall_pct = 30;
    set_timing(16'd0, 16'd0);
    repeat (12) send_random_item();
    wait_results_drained();
    set_timing(16'hFFFF, 16'd4095);
    repeat (8) send_random_item();
    wait_results_drained();
    set_timing(16'hFFFF, 16'd0);
    repeat (8) send_random_item();
    wait_results_drained();
    set_timing(16'd0, 16'd4095);
    repeat (8) send_random_item();
    wait_results_drained();
  endtask

  // Random items in chunks, with a fresh timing setting between chunks.
  task automatic test_random_traffic(int sender_idle, int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (5) begin
      case ($urandom_range(3))
        0: set_timing(16'($urandom_range(24)), 16'($urandom_range(3)));
        1: set_timing(16'($urandom_range(60)), 16'($urandom_range(8)));
        2: set_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        default: set_timing(16'($urandom_range(40)), 16'($urandom_range(65535)));
      endcase
      repeat (ChunkItems) send_random_item();
      wait_results_drained();
    end
  endtask

  // Reset, then the tests in turn.
  initial begin
    rst               <= 1'b1;
    in_item.valid     <= 1'b0;
    in_item.op        <= OP_TICK;
    in_item.key_code  <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= REG_BASE_PERIOD;
    cfg.data          <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_key_handling();
    test_speed_limits();
    test_shortened_period();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(67, 0);
    test_random_traffic(0, 67);
    test_random_traffic(30, 30);

    wait_results_drained();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ssdseq_pkg.sv
hdl/ssdseq_if.sv
hdl/ssdseq_period.sv
hdl/stepper_speed_direction_sequencer.sv
hdl/ssdseq_checker.sv
dv/testbench.sv
